### hw/rtl/dssd_pkg.sv
// dssd_pkg: shared types, codes and segment table for the seven-segment display writer
// used by dssd_conv, dssd_burst and decimal_seven_segment_display_writer
`default_nettype none

package dssd_pkg;

  localparam logic [7:0]  CMD_DISPLAY_ON  = 8'h48;
  localparam logic [7:0]  CMD_DIGIT_BASE  = 8'h68;
  localparam logic [7:0]  CONTROL_RESET   = 8'h01;
  localparam logic [13:0] NUMBER_MAX      = 14'd9999;
  localparam logic [4:0]  BLANK_CODE      = 5'd16;
  localparam int          NUM_DIGITS      = 4;

  typedef enum logic [1:0] {
    REQ_DISPLAY_ON = 2'd0,
    REQ_NUMBER     = 2'd1,
    REQ_DIGIT      = 2'd2
  } req_code_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] number_value;
    logic [1:0]  digit_index;
    logic [4:0]  digit_code;
  } dssd_in_t;

  typedef struct packed {
    logic [7:0] cmd_address;
    logic [7:0] cmd_data;
    logic       last;
  } dssd_out_t;

  // after the thousands split
  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] digit_index;
    logic [4:0] digit_code;
    logic [3:0] d_thou;
    logic [9:0] rem;
  } dssd_thou_t;

  // after the hundreds split, handed to the command burst
  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] digit_index;
    logic [4:0] digit_code;
    logic [3:0] d_thou;
    logic [3:0] d_hund;
    logic [6:0] rem;
  } dssd_work_t;

  function automatic logic [7:0] seg_pattern(input logic [4:0] code);
    logic [7:0] pat;
    if (code >= BLANK_CODE) begin
      pat = 8'h00;
    end else begin
      case (code[3:0])
        4'h0: pat = 8'h3f;
        4'h1: pat = 8'h06;
        4'h2: pat = 8'h5b;
        4'h3: pat = 8'h4f;
        4'h4: pat = 8'h66;
        4'h5: pat = 8'h6d;
        4'h6: pat = 8'h7d;
        4'h7: pat = 8'h07;
        4'h8: pat = 8'h7f;
        4'h9: pat = 8'h6f;
        4'ha: pat = 8'h77;
        4'hb: pat = 8'h7c;
        4'hc: pat = 8'h39;
        4'hd: pat = 8'h5e;
        4'he: pat = 8'h79;
        4'hf: pat = 8'h71;
        default: pat = 8'h00;
      endcase
    end
    return pat;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/decimal_seven_segment_display_writer.sv
// Seven-segment display command writer. Each request word turns into display
// commands (address byte, data byte, last flag). Display-on and single-digit
// requests give one command each and can be taken every cycle while the output
// does not stall; a number request gives four digit commands, one per cycle
// while the output does not stall. A request passes the input register, thousands
// split, hundreds split and command register before its first command appears.
// Numbers above 9999 show as 9999 and leading zeros are blanked.
// depends on dssd_pkg, dssd_conv, dssd_burst
`default_nettype none

module decimal_seven_segment_display_writer
  import dssd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dssd_in_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dssd_out_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] display_control;
  logic       work_valid;
  logic       work_ready;
  dssd_work_t work_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_control <= CONTROL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      display_control <= cfg_data;
    end
  end

  dssd_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .work_valid (work_valid),
    .work_ready (work_ready),
    .work_data  (work_data)
  );

  dssd_burst u_burst (
    .clk             (clk),
    .rst             (rst),
    .display_control (display_control),
    .work_valid      (work_valid),
    .work_ready      (work_ready),
    .work_data       (work_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data)
  );

`ifndef SYNTHESIS
  // a number burst runs without gaps once started
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last |=> out_valid)
    else $error("number burst broken");

  // digit addresses step by two within a burst
  a_burst_address_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last |=>
      out_data.cmd_address == $past(out_data.cmd_address) + 8'd2)
    else $error("burst address did not advance");

  // only the first three digits of a number come without last
  a_nonlast_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |->
      out_data.cmd_address == CMD_DIGIT_BASE ||
      out_data.cmd_address == CMD_DIGIT_BASE + 8'd2 ||
      out_data.cmd_address == CMD_DIGIT_BASE + 8'd4)
    else $error("non-last word outside the digit range");
`endif

endmodule

`default_nettype wire

### hw/rtl/dssd_conv.sv
// dssd_conv: input register and the thousands and hundreds digit split stages
// depends on dssd_pkg
`default_nettype none

module dssd_conv
  import dssd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dssd_in_t   in_data,
  output logic            work_valid,
  input  wire logic       work_ready,
  output dssd_work_t      work_data
);

  logic       in_reg_valid;
  dssd_in_t   in_reg;
  logic       thou_valid;
  dssd_thou_t thou;
  logic       hund_valid;
  dssd_work_t hund;

  logic       in_reg_ready;
  logic       thou_ready;
  logic       hund_ready;

  dssd_thou_t thou_next;
  dssd_work_t hund_next;

  logic [13:0] num_clamped;
  logic [13:0] thou_base;
  logic [9:0]  hund_base;

  assign hund_ready   = !hund_valid || work_ready;
  assign thou_ready   = !thou_valid || hund_ready;
  assign in_reg_ready = !in_reg_valid || thou_ready;
  assign in_stall     = !in_reg_ready;

  // thousands digit by parallel compares against constant multiples
  always_comb begin
    num_clamped = (in_reg.number_value > 16'(NUMBER_MAX)) ? NUMBER_MAX
                                                          : in_reg.number_value[13:0];
    thou_next.req_type    = in_reg.req_type;
    thou_next.digit_index = in_reg.digit_index;
    thou_next.digit_code  = in_reg.digit_code;
    thou_next.d_thou      = 4'd0;
    thou_base             = 14'd0;
    for (int k = 1; k < 10; k++) begin
      if (num_clamped >= 14'(k * 1000)) begin
        thou_next.d_thou = 4'(k);
        thou_base        = 14'(k * 1000);
      end
    end
    thou_next.rem = 10'(num_clamped - thou_base);
  end

  always_comb begin
    hund_next.req_type    = thou.req_type;
    hund_next.digit_index = thou.digit_index;
    hund_next.digit_code  = thou.digit_code;
    hund_next.d_thou      = thou.d_thou;
    hund_next.d_hund      = 4'd0;
    hund_base             = 10'd0;
    for (int k = 1; k < 10; k++) begin
      if (thou.rem >= 10'(k * 100)) begin
        hund_next.d_hund = 4'(k);
        hund_base        = 10'(k * 100);
      end
    end
    hund_next.rem = 7'(thou.rem - hund_base);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      thou_valid   <= 1'b0;
      hund_valid   <= 1'b0;
    end else begin
      if (in_reg_ready) begin
        in_reg_valid <= in_valid;
      end
      if (thou_ready) begin
        thou_valid <= in_reg_valid;
      end
      if (hund_ready) begin
        hund_valid <= thou_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_reg_ready && in_valid) begin
      in_reg <= in_data;
    end
    if (thou_ready && in_reg_valid) begin
      thou <= thou_next;
    end
    if (hund_ready && thou_valid) begin
      hund <= hund_next;
    end
  end

  assign work_valid = hund_valid;
  assign work_data  = hund;

endmodule

`default_nettype wire

### hw/rtl/dssd_burst.sv
// dssd_burst: builds the commands of one request and sends them one word a cycle while the output does not stall
// depends on dssd_pkg
`default_nettype none

module dssd_burst
  import dssd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  display_control,
  input  wire logic        work_valid,
  output logic             work_ready,
  input  wire dssd_work_t  work_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output dssd_out_t        out_data
);

  dssd_out_t  ent      [NUM_DIGITS];
  dssd_out_t  ent_next [NUM_DIGITS];
  dssd_out_t  load_ent [NUM_DIGITS];
  logic [2:0] cnt;
  logic [2:0] cnt_next;
  logic [2:0] load_cnt;

  logic       pop;
  logic       load;
  logic [3:0] digit [NUM_DIGITS];
  logic [3:0] d_tens;
  logic [6:0] tens_base;
  logic       seen;

  assign pop        = (cnt != 3'd0) && !out_stall;
  assign work_ready = (cnt == 3'd0) || ((cnt == 3'd1) && !out_stall);
  assign load       = work_valid && work_ready;

  always_comb begin
    d_tens    = 4'd0;
    tens_base = 7'd0;
    for (int k = 1; k < 10; k++) begin
      if (work_data.rem >= 7'(k * 10)) begin
        d_tens    = 4'(k);
        tens_base = 7'(k * 10);
      end
    end
    digit[0] = work_data.d_thou;
    digit[1] = work_data.d_hund;
    digit[2] = d_tens;
    digit[3] = 4'(work_data.rem - tens_base);

    for (int k = 0; k < NUM_DIGITS; k++) begin
      load_ent[k] = '{cmd_address: 8'h00, cmd_data: 8'h00, last: 1'b0};
    end
    load_cnt = 3'd0;
    seen     = 1'b0;

    case (work_data.req_type)
      REQ_DISPLAY_ON: begin
        load_ent[0] = '{cmd_address: CMD_DISPLAY_ON, cmd_data: display_control, last: 1'b1};
        load_cnt    = 3'd1;
      end
      REQ_NUMBER: begin
        // leading zero positions blank, the rightmost always shows
        for (int k = 0; k < NUM_DIGITS; k++) begin
          seen = seen || (digit[k] != 4'd0) || (k == NUM_DIGITS - 1);
          load_ent[k].cmd_address = 8'(CMD_DIGIT_BASE + 2 * k);
          load_ent[k].cmd_data    = seen ? seg_pattern({1'b0, digit[k]}) : 8'h00;
          load_ent[k].last        = (k == NUM_DIGITS - 1);
        end
        load_cnt = 3'(NUM_DIGITS);
      end
      REQ_DIGIT: begin
        load_ent[0].cmd_address = CMD_DIGIT_BASE + {5'd0, work_data.digit_index, 1'b0};
        load_ent[0].cmd_data    = seg_pattern(work_data.digit_code);
        load_ent[0].last        = 1'b1;
        load_cnt                = 3'd1;
      end
      default: begin
        load_cnt = 3'd0;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      ent_next[k] = ent[k];
    end
    cnt_next = cnt;
    if (pop) begin
      for (int k = 0; k < NUM_DIGITS - 1; k++) begin
        ent_next[k] = ent[k + 1];
      end
      cnt_next = cnt - 3'd1;
    end
    if (load) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        ent_next[k] = load_ent[k];
      end
      cnt_next = load_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      ent[k] <= ent_next[k];
    end
  end

  assign out_valid = (cnt != 3'd0);
  assign out_data  = ent[0];

endmodule

`default_nettype wire
